### rtl/phc_pkg.sv
// phc_pkg: types, register indexes and helpers for the packer handshake controller
// depends on nothing; used by phc_release and packer_handshake_controller
package phc_pkg;

	typedef enum logic [2:0] {
		REG_HANDSHAKE_ENABLE = 3'd0,
		REG_REQUEST_TRIGGER  = 3'd1,
		REG_OUTPUT_POLARITY  = 3'd2,
		REG_ASYNC_REQUEST    = 3'd3,
		REG_WEIGHER_INIT     = 3'd4,
		REG_FEEDS_PER_REQ    = 3'd5,
		REG_RELEASE_DELAY    = 3'd6,
		REG_PULSE_WIDTH      = 3'd7
	} reg_index_t;

	localparam logic [1:0] TRIG_LOW  = 2'd0;
	localparam logic [1:0] TRIG_RISE = 2'd1;
	localparam logic [1:0] TRIG_FALL = 2'd2;
	localparam logic [1:0] TRIG_HIGH = 2'd3;

	localparam logic [1:0] PEND_RISE = 2'b10;
	localparam logic [1:0] PEND_FALL = 2'b01;
	localparam logic [1:0] PEND_BOTH = 2'b11;

	localparam logic [7:0] MIN_PULSE = 8'd5;

	typedef struct packed {
		logic       handshake_enable;
		logic [1:0] request_trigger;
		logic [1:0] output_polarity;
		logic       async_request;
		logic       weigher_initiates;
		logic [3:0] feeds_per_request;
		logic [4:0] release_delay;
		logic [7:0] pulse_width;
	} cfg_t;

	// release sequencer status for the current tick
	typedef struct packed {
		logic idle_svc;
		logic busy;
		logic pulse_on;
		logic done;
	} rel_status_t;

	function automatic logic [7:0] eff_width(input logic [7:0] w);
		return (w < MIN_PULSE) ? MIN_PULSE : w;
	endfunction

endpackage

### rtl/phc_release.sv
// phc_release: release sequencer, optional delay then feed-done pulse
// depends on phc_pkg
module phc_release #(
	parameter int DELAY_UNIT_TICKS = 20,
	parameter int DW = 10
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  phc_pkg::cfg_t             cfg,
	input  logic                      tick,
	input  logic                      start_req,
	output phc_pkg::rel_status_t      status
);
	import phc_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_DELAY = 3'b010,
		PH_PULSE = 3'b100
	} phase_t;

	phase_t        phase_q, ph_svc, ph_n;
	logic [DW-1:0] dt_q, dt_svc, dt_n, dt_dec;
	logic [7:0]    ft_q, ft_svc, ft_n, ft_dec, eff_w;
	logic          start, done;

	always_comb begin
		eff_w  = eff_width(cfg.pulse_width);
		ph_svc = phase_q;
		dt_svc = dt_q;
		ft_svc = ft_q;
		done   = 1'b0;
		dt_dec = (dt_q != '0) ? dt_q - 1'b1 : dt_q;
		ft_dec = (ft_q != '0) ? ft_q - 1'b1 : ft_q;
		case (phase_q)
			PH_IDLE: begin
			end
			PH_DELAY: begin
				dt_svc = dt_dec;
				if (dt_dec == '0) begin
					ft_svc = eff_w;
					ph_svc = PH_PULSE;
				end
			end
			PH_PULSE: begin
				ft_svc = ft_dec;
				if (ft_dec == '0) begin
					ph_svc = PH_IDLE;
					done   = 1'b1;
				end
			end
			default: ph_svc = PH_IDLE;
		endcase

		start = start_req && (ph_svc == PH_IDLE);
		ph_n  = ph_svc;
		dt_n  = dt_svc;
		ft_n  = ft_svc;
		if (start) begin
			if (cfg.release_delay != '0) begin
				dt_n = DW'(cfg.release_delay) * DW'(DELAY_UNIT_TICKS);
				ph_n = PH_DELAY;
			end else begin
				ft_n = eff_w;
				ph_n = PH_PULSE;
			end
		end

		status.idle_svc = (ph_svc == PH_IDLE);
		status.busy     = (ph_n != PH_IDLE);
		status.pulse_on = (ph_n == PH_PULSE) && (ft_n != '0);
		status.done     = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			dt_q    <= '0;
			ft_q    <= '0;
		end else if (tick) begin
			phase_q <= ph_n;
			dt_q    <= dt_n;
			ft_q    <= ft_n;
		end
	end

	a_pulse_timer_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PULSE) |-> (ft_q != '0))
		else $error("feed-done pulse phase with expired timer");

	a_delay_timer_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DELAY) |-> (dt_q != '0))
		else $error("delay phase with expired timer");

	a_start_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && start) |=> (phase_q != PH_IDLE))
		else $error("release start did not leave idle");

endmodule

### rtl/packer_handshake_controller.sv
// packer_handshake_controller: top level, config registers, edge and feed logic
// depends on phc_pkg and phc_release
// Each input transfer is one 10 ms tick and yields one result transfer. A tick
// is worked out in combinational logic between the state registers and the
// result register, so one transfer is taken every clock cycle and its result is
// offered on the cycle after it; the input stalls only while the result register
// is full and not being taken.
module packer_handshake_controller #(
	parameter int DEBOUNCE_TICKS   = 15,
	parameter int DELAY_UNIT_TICKS = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wen,
	input  logic [2:0] cfg_addr,
	input  logic [7:0] cfg_wdata,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // request_level, combination_ready, release_strobe
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata   // ready_pin, feed_done_pin, packer_free,
	                                  // release_busy, release_complete
);
	import phc_pkg::*;

	localparam int HW = $clog2(DEBOUNCE_TICKS + 1);
	localparam int DW = $clog2(31 * DELAY_UNIT_TICKS + 1);

	cfg_t        cfg_q;
	rel_status_t rel_st;

	logic          last_level_q, wready_q, multi_q;
	logic [1:0]    pend_q, pend_n;
	logic [3:0]    fc_q, fc_n, fc_edge, fc_inc;
	logic [HW-1:0] hold_q, hold_n;
	logic [7:0]    rt_q, rt_n;
	logic          wready_n, multi_n;

	logic          level, comb, rel, tick, rel_taken, last_feed, ready, held, complete;
	logic          out_valid_q;
	logic [4:0]    out_q, result;

	assign level = s_axis_tdata[0];
	assign comb  = s_axis_tdata[1];
	assign rel   = s_axis_tdata[2];

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign tick          = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.handshake_enable  <= 1'b0;
			cfg_q.request_trigger   <= TRIG_LOW;
			cfg_q.output_polarity   <= 2'd0;
			cfg_q.async_request     <= 1'b0;
			cfg_q.weigher_initiates <= 1'b0;
			cfg_q.feeds_per_request <= 4'd1;
			cfg_q.release_delay     <= 5'd0;
			cfg_q.pulse_width       <= MIN_PULSE;
		end else if (cfg_wen) begin
			case (reg_index_t'(cfg_addr))
				REG_HANDSHAKE_ENABLE: cfg_q.handshake_enable  <= cfg_wdata[0];
				REG_REQUEST_TRIGGER:  cfg_q.request_trigger   <= cfg_wdata[1:0];
				REG_OUTPUT_POLARITY:  cfg_q.output_polarity   <= cfg_wdata[1:0];
				REG_ASYNC_REQUEST:    cfg_q.async_request     <= cfg_wdata[0];
				REG_WEIGHER_INIT:     cfg_q.weigher_initiates <= cfg_wdata[0];
				REG_FEEDS_PER_REQ:    cfg_q.feeds_per_request <= cfg_wdata[3:0];
				REG_RELEASE_DELAY:    cfg_q.release_delay     <= cfg_wdata[4:0];
				REG_PULSE_WIDTH:      cfg_q.pulse_width       <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		rt_n     = (rt_q != '0) ? rt_q - 1'b1 : rt_q;
		pend_n   = pend_q;
		fc_edge  = fc_q;
		hold_n   = hold_q;
		wready_n = wready_q;
		multi_n  = multi_q;

		// edge detection on the request pin
		if (level != last_level_q) begin
			hold_n = '0;
			if (cfg_q.handshake_enable) begin
				if (cfg_q.async_request || wready_q) begin
					pend_n = pend_q | (level ? PEND_RISE : PEND_FALL);
				end else begin
					pend_n = 2'b00;
				end
				fc_edge = 4'd0;
			end
		end else if (hold_q < HW'(DEBOUNCE_TICKS)) begin
			hold_n = hold_q + 1'b1;
		end

		if (comb) begin
			rt_n     = eff_width(cfg_q.pulse_width);
			wready_n = 1'b1;
		end

		// release strobe: count feeds
		fc_inc    = fc_edge + 4'd1;
		last_feed = !(fc_inc < cfg_q.feeds_per_request);
		rel_taken = rel && rel_st.idle_svc;
		fc_n      = fc_edge;
		complete  = rel_st.done;
		if (rel_taken) begin
			wready_n = 1'b0;
			if (!last_feed) begin
				pend_n   = PEND_BOTH;
				multi_n  = 1'b1;
				fc_n     = fc_inc;
				complete = 1'b1;
			end else begin
				pend_n  = 2'b00;
				multi_n = 1'b0;
				fc_n    = 4'd0;
			end
		end

		held = (hold_n >= HW'(DEBOUNCE_TICKS));
		if (!cfg_q.handshake_enable || multi_n) begin
			ready = 1'b1;
		end else begin
			case (cfg_q.request_trigger)
				TRIG_LOW:  ready = !level && (pend_n[0] || held);
				TRIG_RISE: ready = pend_n[1];
				TRIG_FALL: ready = pend_n[0];
				TRIG_HIGH: ready = level && (pend_n[1] || held);
				default:   ready = 1'b0;
			endcase
		end

		result[0] = ((rt_n != '0) == cfg_q.output_polarity[1]);
		result[1] = (rel_st.pulse_on == cfg_q.output_polarity[1]);
		result[2] = ready;
		result[3] = rel_st.busy;
		result[4] = complete;
	end

	phc_release #(
		.DELAY_UNIT_TICKS(DELAY_UNIT_TICKS),
		.DW(DW)
	) u_release (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.tick     (tick),
		.start_req(tick && rel && last_feed),
		.status   (rel_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= 1'b0;
			pend_q       <= 2'b00;
			wready_q     <= 1'b0;
			multi_q      <= 1'b0;
			fc_q         <= 4'd0;
			hold_q       <= '0;
			rt_q         <= '0;
		end else begin
			if (cfg_wen && (reg_index_t'(cfg_addr) == REG_WEIGHER_INIT) && cfg_wdata[0]) begin
				pend_q <= PEND_BOTH;
			end else if (tick) begin
				pend_q <= pend_n;
			end
			if (tick) begin
				last_level_q <= level;
				wready_q     <= wready_n;
				multi_q      <= multi_n;
				fc_q         <= fc_n;
				hold_q       <= hold_n;
				rt_q         <= rt_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tick) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_q};

	a_hold_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q <= HW'(DEBOUNCE_TICKS))
		else $error("hold counter past debounce limit");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result transfer changed or dropped");

	a_empty_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty result register");

endmodule

### verif/packer_handshake_controller_tb.sv
// packer_handshake_controller_tb: self-checking bench for the packer handshake controller
// streams request-pin ticks through the block under several register settings and
// checks every result tick against a cycle-free model of the handshake; needs phc_pkg
module packer_handshake_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import phc_pkg::*;

	localparam int DEBOUNCE = 15;
	localparam int DELAY_UNIT = 20;
	localparam int CYCLE_LIMIT = 300000;
	localparam int TICKS_PER_SETTING = 88;

	typedef struct packed {
		logic release_strobe;
		logic combination_ready;
		logic request_level;
	} tick_in_t;

	typedef struct packed {
		logic release_complete;
		logic release_busy;
		logic packer_free;
		logic feed_done_pin;
		logic ready_pin;
	} tick_out_t;

	typedef enum logic [1:0] {PH_IDLE, PH_DELAY, PH_PULSE} rel_phase_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wen = 1'b0;
	logic [2:0] cfg_addr = '0;
	logic [7:0] cfg_wdata = '0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = '0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;

	tick_in_t  tick_q[$];
	tick_out_t expected_q[$];

	// model state
	cfg_t       regs;
	logic       pin_last;
	logic [1:0] pend;
	logic       wgh_ready;
	logic       multi_feed;
	logic [3:0] feed_cnt;
	logic [3:0] hold_cnt;
	logic [7:0] ready_tmr;
	logic [7:0] feed_tmr;
	logic [9:0] delay_tmr;
	rel_phase_t rel_phase;

	int burst_left = 0;
	int gap_left = 0;
	int rx_cnt = 0;
	int cycle_cnt = 0;
	int err_cnt = 0;
	int ticks_in = 0;
	int results_seen = 0;
	int releases_done = 0;
	int packer_free_ticks = 0;
	int settings_used = 0;
	logic stim_level = 1'b0;
	int run_left = 0;

	string field_name[5] = '{"ready_pin", "feed_done_pin", "packer_free",
		"release_busy", "release_complete"};

	packer_handshake_controller #(
		.DEBOUNCE_TICKS(DEBOUNCE),
		.DELAY_UNIT_TICKS(DELAY_UNIT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic tick_out_t advance_tick(input tick_in_t t);
		tick_out_t  r;
		logic [7:0] w;
		logic       done;
		logic       ready;
		logic       held;
		logic       active_high;
		w = (regs.pulse_width < 8'd5) ? 8'd5 : regs.pulse_width;
		done = 1'b0;
		if (ready_tmr != 0) ready_tmr = ready_tmr - 8'd1;
		case (rel_phase)
			PH_DELAY: begin
				if (delay_tmr != 0) delay_tmr = delay_tmr - 10'd1;
				if (delay_tmr == 0) begin
					feed_tmr = w;
					rel_phase = PH_PULSE;
				end
			end
			PH_PULSE: begin
				if (feed_tmr != 0) feed_tmr = feed_tmr - 8'd1;
				if (feed_tmr == 0) begin
					rel_phase = PH_IDLE;
					done = 1'b1;
				end
			end
			default: rel_phase = PH_IDLE;
		endcase

		if (t.request_level != pin_last) begin
			hold_cnt = '0;
			if (regs.handshake_enable) begin
				if (regs.async_request || wgh_ready)
					pend = pend | (t.request_level ? PEND_RISE : PEND_FALL);
				else
					pend = '0;
				feed_cnt = '0;
			end
		end else if (hold_cnt < 4'(DEBOUNCE)) begin
			hold_cnt = hold_cnt + 4'd1;
		end
		pin_last = t.request_level;

		if (t.combination_ready) begin
			ready_tmr = w;
			wgh_ready = 1'b1;
		end

		if (t.release_strobe && rel_phase == PH_IDLE) begin
			wgh_ready = 1'b0;
			feed_cnt = feed_cnt + 4'd1;
			if (feed_cnt < regs.feeds_per_request) begin
				pend = PEND_BOTH;
				multi_feed = 1'b1;
				done = 1'b1;
			end else begin
				pend = '0;
				multi_feed = 1'b0;
				feed_cnt = '0;
				if (regs.release_delay != 0) begin
					delay_tmr = 10'(regs.release_delay * DELAY_UNIT);
					rel_phase = PH_DELAY;
				end else begin
					feed_tmr = w;
					rel_phase = PH_PULSE;
				end
			end
		end

		if (!regs.handshake_enable || multi_feed) begin
			ready = 1'b1;
		end else begin
			held = hold_cnt >= 4'(DEBOUNCE);
			case (regs.request_trigger)
				TRIG_LOW:  ready = !t.request_level && (pend[0] || held);
				TRIG_RISE: ready = pend[1];
				TRIG_FALL: ready = pend[0];
				default:   ready = t.request_level && (pend[1] || held);
			endcase
		end

		active_high = regs.output_polarity[1];
		r.ready_pin = (ready_tmr != 0) == active_high;
		r.feed_done_pin = (rel_phase == PH_PULSE && feed_tmr != 0) == active_high;
		r.packer_free = ready;
		r.release_busy = rel_phase != PH_IDLE;
		r.release_complete = done;
		return r;
	endfunction

	// model update and result check
	always @(posedge clk or negedge arst_n) begin
		tick_out_t got;
		tick_out_t want;
		if (!arst_n) begin
			regs = '0;
			regs.feeds_per_request = 4'd1;
			regs.pulse_width = 8'd5;
			pin_last = 1'b0;
			pend = '0;
			wgh_ready = 1'b0;
			multi_feed = 1'b0;
			feed_cnt = '0;
			hold_cnt = '0;
			ready_tmr = '0;
			feed_tmr = '0;
			delay_tmr = '0;
			rel_phase = PH_IDLE;
		end else begin
			if (cfg_wen) begin
				case (reg_index_t'(cfg_addr))
					REG_HANDSHAKE_ENABLE: regs.handshake_enable = cfg_wdata[0];
					REG_REQUEST_TRIGGER:  regs.request_trigger = cfg_wdata[1:0];
					REG_OUTPUT_POLARITY:  regs.output_polarity = cfg_wdata[1:0];
					REG_ASYNC_REQUEST:    regs.async_request = cfg_wdata[0];
					REG_WEIGHER_INIT: begin
						regs.weigher_initiates = cfg_wdata[0];
						if (cfg_wdata[0]) pend = PEND_BOTH;
					end
					REG_FEEDS_PER_REQ:    regs.feeds_per_request = cfg_wdata[3:0];
					REG_RELEASE_DELAY:    regs.release_delay = cfg_wdata[4:0];
					default:              regs.pulse_width = cfg_wdata;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expected_q.push_back(advance_tick(tick_in_t'(s_axis_tdata[2:0])));
				ticks_in++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = tick_out_t'(m_axis_tdata[4:0]);
				results_seen++;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result transfer, expected none, got %b",
						$time, got);
					err_cnt++;
				end else begin
					want = expected_q.pop_front();
					for (int b = 0; b < 5; b++)
						if (got[b] !== want[b]) begin
							$display("%0t: %s mismatch, expected %b got %b", $time,
								field_name[b], want[b], got[b]);
							err_cnt++;
						end
					if (want.release_complete) releases_done++;
					if (want.packer_free) packer_free_ticks++;
				end
			end
		end
	end

	// sender: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (gap_left != 0 || tick_q.size() == 0) begin
				s_axis_tvalid <= 1'b0;
				if (gap_left != 0) gap_left <= gap_left - 1;
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {5'b0, tick_q.pop_front()};
				if (burst_left > 1) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
		end
	end

	// receiver: stall pattern picked by bits 9:8 of a free-running cycle counter
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_cnt <= 0;
		end else begin
			rx_cnt <= rx_cnt + 1;
			case (rx_cnt[9:8])
				2'd0: m_axis_tready <= 1'b1;
				2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
				2'd2: m_axis_tready <= rx_cnt[5:0] < 6'd40;
				default: m_axis_tready <= $urandom_range(0, 7) != 0;
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				expected_q.size());
			$display("FAIL");
			$finish;
		end
	end

	task automatic queue_tick(input logic lvl, input logic comb, input logic rel);
		tick_in_t t;
		t.request_level = lvl;
		t.combination_ready = comb;
		t.release_strobe = rel;
		tick_q.push_back(t);
	endtask

	// pin held in runs, some long enough to pass the debounce hold, plus noise
	task automatic queue_random_ticks(input int n);
		for (int i = 0; i < n; i++) begin
			if (run_left == 0) begin
				stim_level = ($urandom_range(0, 5) == 0) ? stim_level : !stim_level;
				run_left = ($urandom_range(0, 2) == 0) ? $urandom_range(15, 24)
					: $urandom_range(1, 6);
			end
			run_left--;
			if ($urandom_range(0, 11) == 0)
				queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			else
				queue_tick(stim_level, $urandom_range(0, 5) == 0, $urandom_range(0, 4) == 0);
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (tick_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(input cfg_t c);
		reg_index_t idx;
		logic [7:0] val;
		for (int i = 0; i < 8; i++) begin
			idx = reg_index_t'(i);
			case (idx)
				REG_HANDSHAKE_ENABLE: val = {7'b0, c.handshake_enable};
				REG_REQUEST_TRIGGER:  val = {6'b0, c.request_trigger};
				REG_OUTPUT_POLARITY:  val = {6'b0, c.output_polarity};
				REG_ASYNC_REQUEST:    val = {7'b0, c.async_request};
				REG_WEIGHER_INIT:     val = {7'b0, c.weigher_initiates};
				REG_FEEDS_PER_REQ:    val = {4'b0, c.feeds_per_request};
				REG_RELEASE_DELAY:    val = {3'b0, c.release_delay};
				default:              val = c.pulse_width;
			endcase
			@(posedge clk);
			cfg_wen <= 1'b1;
			cfg_addr <= idx;
			cfg_wdata <= val;
		end
		@(posedge clk);
		cfg_wen <= 1'b0;
		settings_used++;
	endtask

	initial begin
		cfg_t plan[8];
		plan[0] = '{1'b1, TRIG_LOW,  2'd0, 1'b0, 1'b1, 4'd1,  5'd0,  8'd5};
		plan[1] = '{1'b1, TRIG_HIGH, 2'd3, 1'b1, 1'b0, 4'd3,  5'd1,  8'd6};
		plan[2] = '{1'b1, TRIG_FALL, 2'd1, 1'b0, 1'b0, 4'd15, 5'd0,  8'd0};
		plan[3] = '{1'b0, TRIG_RISE, 2'd2, 1'b1, 1'b1, 4'd0,  5'd2,  8'd4};
		plan[4] = '{1'b1, TRIG_RISE, 2'd0, 1'b1, 1'b1, 4'd8,  5'd0,  8'd255};
		plan[5] = '{1'b1, TRIG_HIGH, 2'd2, 1'b0, 1'b0, 4'd2,  5'd31, 8'd5};
		plan[6] = '{1'b1, TRIG_LOW,  2'd3, 1'b1, 1'b0, 4'd1,  5'd0,  8'd1};
		plan[7] = cfg_t'(24'($urandom));

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: edges, strobes, multi-feed, last feed, release while busy
		program_regs('{1'b1, TRIG_RISE, 2'd2, 1'b1, 1'b0, 4'd2, 5'd0, 8'd0});
		@(negedge clk);
		queue_tick(0, 0, 0);
		queue_tick(1, 0, 0);
		queue_tick(1, 1, 0);
		queue_tick(1, 0, 1);
		queue_tick(0, 0, 0);
		queue_tick(0, 0, 1);
		queue_tick(0, 0, 1);
		queue_tick(1, 1, 1);
		repeat (4) queue_tick(1, 0, 0);
		queue_tick(0, 0, 0);
		queue_tick(0, 1, 0);
		queue_tick(1, 0, 1);
		repeat (3) queue_tick(1, 0, 0);
		queue_tick(0, 1, 1);
		repeat (4) queue_tick(0, 0, 0);
		queue_tick(1, 1, 1);
		wait_drained();

		foreach (plan[p]) begin
			program_regs(plan[p]);
			@(negedge clk);
			queue_random_ticks(TICKS_PER_SETTING / 2);
			wait_drained();
			@(negedge clk);
			queue_random_ticks(TICKS_PER_SETTING - TICKS_PER_SETTING / 2);
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (expected_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, expected_q.size());
			err_cnt++;
		end
		$display("%0d ticks over %0d register settings, %0d results checked",
			ticks_in, settings_used, results_seen);
		$display("%0d release completions, %0d ticks with packer free, %0d errors",
			releases_done, packer_free_ticks, err_cnt);
		if (err_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

### filelist.f
rtl/phc_pkg.sv
rtl/phc_release.sv
rtl/packer_handshake_controller.sv
verif/packer_handshake_controller_tb.sv
